/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/arbc_pkg.sv */
// Shared types, register codes and helpers for the auto-repeat cursor.
`default_nettype none
package arbc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_DELAY   = 3'd0,
		REG_SLOW_INTERVAL   = 3'd1,
		REG_FAST_INTERVAL   = 3'd2,
		REG_ACCEL_THRESHOLD = 3'd3,
		REG_ITEM_COUNT      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  initial_delay;
		logic [7:0]  slow_interval;
		logic [7:0]  fast_interval;
		logic [15:0] accel_threshold;
		logic [8:0]  item_count;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGE,
		ST_DIV,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic accept;
		logic edge_step;
		logic div_step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} status_t;

	// Highest cursor position for a given item count (zero counts as one, cap at 256).
	function automatic logic [7:0] upper_bound(input logic [8:0] n);
		logic [8:0] m;
		begin
			m = (n == 9'd0) ? 9'd1 : n;
			if (m[8]) begin
				upper_bound = 8'hFF;
			end else begin
				upper_bound = 8'(m - 9'd1);
			end
		end
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/auto_repeat_bounded_cursor_core.sv */
// Auto-repeat bounded cursor: one frame tick in, one cursor result out.
// Input channel: in_valid/in_stall with left_edge, right_edge, left_level,
// right_level; one transaction per display frame.
// Output channel: out_valid/out_stall with cursor_index and moved; exactly one
// result transaction per input transaction, in order.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; write
// only while no frame is in flight.
// Sequence from input transaction to result valid: accept, edge step, one
// remainder bit per cycle in the bit-serial remainder unit, output load. A
// frame with no repeat candidate skips the remainder unit. in_stall stays high
// until the current frame has reached the output load, so frames do not overlap.
// A new frame is taken while the previous result still waits in the output
// register. If the receiver stalls, the result holds and the next frame stops
// at the output load until the register frees.
// Reset: cursor and both hold counters clear, registers return to their
// defaults, no result is pending.
`default_nettype none
`include "assert_macros.svh"
module auto_repeat_bounded_cursor_core #(
	parameter int HOLD_COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            left_edge,
	input  logic                            right_edge,
	input  logic                            left_level,
	input  logic                            right_level,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      cursor_index,
	output logic                            moved,
	input  logic                            cfg_we,
	input  logic [arbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arbc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import arbc_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	logic    busy;

	arbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	arbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.busy     (busy),
		.cmd      (cmd)
	);

	arbc_dp #(
		.HOLD_W (HOLD_COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.left_edge    (left_edge),
		.right_edge   (right_edge),
		.left_level   (left_level),
		.right_level  (right_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cursor_index (cursor_index),
		.moved        (moved)
	);

	assign in_stall = busy;

	`ASSERT_NEXT(a_accept_then_edge, clk, arst_n, in_valid && !in_stall, cmd.edge_step)
	`ASSERT_IMPLIES(a_load_needs_room, clk, arst_n, cmd.load, !out_valid || !out_stall)
	`ASSERT_NEXT(a_div_runs_out, clk, arst_n, cmd.div_step && !status.div_last, cmd.div_step)

endmodule
`default_nettype wire

/* hw/rtl/arbc_cfg.sv */
// Configuration register file for the auto-repeat cursor.
`default_nettype none
module arbc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [arbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arbc_pkg::CFG_DATA_W-1:0] cfg_data,
	output arbc_pkg::cfg_t                  cfg
);
	import arbc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_delay   <= 8'd20;
			cfg_q.slow_interval   <= 8'd6;
			cfg_q.fast_interval   <= 8'd2;
			cfg_q.accel_threshold <= 16'd60;
			cfg_q.item_count      <= 9'd10;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INITIAL_DELAY:   cfg_q.initial_delay   <= cfg_data[7:0];
				REG_SLOW_INTERVAL:   cfg_q.slow_interval   <= cfg_data[7:0];
				REG_FAST_INTERVAL:   cfg_q.fast_interval   <= cfg_data[7:0];
				REG_ACCEL_THRESHOLD: cfg_q.accel_threshold <= cfg_data[15:0];
				REG_ITEM_COUNT:      cfg_q.item_count      <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* hw/rtl/arbc_ctrl.sv */
// Controller state machine sequencing edge, remainder and output phases.
`default_nettype none
module arbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  arbc_pkg::status_t  status,
	output logic               busy,
	output arbc_pkg::cmd_t     cmd
);
	import arbc_pkg::*;

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EDGE;
			end
			ST_EDGE: begin
				state_next = status.need_div ? ST_DIV : ST_APPLY;
			end
			ST_DIV: begin
				if (status.div_last) state_next = ST_APPLY;
			end
			ST_APPLY: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = in_valid;
			end
			ST_EDGE:  cmd.edge_step = 1'b1;
			ST_DIV:   cmd.div_step  = 1'b1;
			ST_APPLY: cmd.load      = status.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/arbc_dp.sv */
// Datapath: cursor, hold counters, bit-serial remainder unit and output register.
`default_nettype none
module arbc_dp #(
	parameter int HOLD_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  arbc_pkg::cfg_t    cfg,
	input  arbc_pkg::cmd_t    cmd,
	output arbc_pkg::status_t status,
	input  logic              left_edge,
	input  logic              right_edge,
	input  logic              left_level,
	input  logic              right_level,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        cursor_index,
	output logic              moved
);
	import arbc_pkg::*;

	localparam int CNT_W = (HOLD_W > 1) ? $clog2(HOLD_W) : 1;
	localparam int CMP_W = (HOLD_W > 16) ? HOLD_W : 16;
	localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

	logic [7:0]        cursor_q;
	logic [HOLD_W-1:0] left_q, right_q;
	logic              le_q, re_q, lh_q, rh_q;
	logic              moved_q;
	logic [HOLD_W-1:0] dvd_q;
	logic [7:0]        rem_q;
	logic [7:0]        int_q;
	logic              ge_q, dir_left_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q, out_moved_q;
	logic [7:0]        out_cursor_q;

	logic [7:0]        ub;
	logic [7:0]        cur_a, cur_b;
	logic              mv_a, mv_b;
	logic              l_act, r_act;
	logic [HOLD_W-1:0] l_base, r_base, l_new, r_new, c_tick;
	logic [HOLD_W-1:0] delay_ext;
	logic              ge;
	logic              fast;
	logic [7:0]        intv;
	logic [8:0]        trial;
	logic [8:0]        trial_sub;
	logic              due;
	logic [7:0]        cur_f;
	logic              mv_f;

	assign ub        = upper_bound(cfg.item_count);
	assign delay_ext = HOLD_W'(cfg.initial_delay);

	// Edge phase: left edge first, then right edge, then counter update.
	always_comb begin
		cur_a = cursor_q;
		mv_a  = 1'b0;
		if (le_q && (cursor_q != 8'd0)) begin
			cur_a = cursor_q - 8'd1;
			mv_a  = 1'b1;
		end
		cur_b = cur_a;
		mv_b  = mv_a;
		if (re_q && (cur_a < ub)) begin
			cur_b = cur_a + 8'd1;
			mv_b  = 1'b1;
		end
	end

	assign l_act  = lh_q & ~rh_q;
	assign r_act  = rh_q & ~lh_q;
	assign l_base = le_q ? '0 : left_q;
	assign r_base = re_q ? '0 : right_q;
	assign l_new  = l_act ? ((l_base == HOLD_MAX) ? l_base : l_base + 1'b1) : '0;
	assign r_new  = r_act ? ((r_base == HOLD_MAX) ? r_base : r_base + 1'b1) : '0;
	assign c_tick = l_act ? l_new : r_new;
	assign ge     = (l_act | r_act) && (c_tick >= delay_ext);
	assign fast   = CMP_W'(c_tick) >= CMP_W'(cfg.accel_threshold);

	always_comb begin
		intv = fast ? cfg.fast_interval : cfg.slow_interval;
		if (intv == 8'd0) intv = 8'd1;
	end

	// One remainder bit per cycle.
	assign trial     = {rem_q, dvd_q[HOLD_W-1]};
	assign trial_sub = trial - {1'b0, int_q};

	// Repeat step after the remainder settles.
	assign due = ge_q && (rem_q == 8'd0);
	always_comb begin
		cur_f = cursor_q;
		mv_f  = moved_q;
		if (due) begin
			if (dir_left_q) begin
				if (cursor_q != 8'd0) begin
					cur_f = cursor_q - 8'd1;
					mv_f  = 1'b1;
				end
			end else if (cursor_q < ub) begin
				cur_f = cursor_q + 8'd1;
				mv_f  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			left_q   <= '0;
			right_q  <= '0;
		end else if (cmd.edge_step) begin
			cursor_q <= cur_b;
			left_q   <= l_new;
			right_q  <= r_new;
		end else if (cmd.load) begin
			cursor_q <= cur_f;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			le_q <= left_edge;
			re_q <= right_edge;
			lh_q <= left_level;
			rh_q <= right_level;
		end
		if (cmd.edge_step) begin
			moved_q    <= mv_b;
			dvd_q      <= c_tick - delay_ext;
			rem_q      <= '0;
			int_q      <= intv;
			ge_q       <= ge;
			dir_left_q <= l_act;
			cnt_q      <= CNT_W'(HOLD_W - 1);
		end else if (cmd.div_step) begin
			rem_q <= trial_sub[8] ? trial[7:0] : trial_sub[7:0];
			dvd_q <= {dvd_q[HOLD_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.load) begin
			out_cursor_q <= cur_f;
			out_moved_q  <= mv_f;
		end
	end

	// Hold the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.need_div = ge;
	assign status.div_last = (cnt_q == '0);
	assign status.out_free = ~out_valid_q | ~out_stall;

	assign out_valid    = out_valid_q;
	assign cursor_index = out_cursor_q;
	assign moved        = out_moved_q;

endmodule
`default_nettype wire
